>>> sv/mfi_pkg.sv
// Shared constants for the money flow index core.
// No dependencies; imported by mfi_ram users and the top level.
`default_nettype none
package mfi_pkg;
    localparam int DEF_MAX_WINDOW = 64;
    localparam int PRICE_W = 24;
    localparam int VOL_W = 28;
    localparam int PSUM_W = 26;
    localparam int FLOW_W = 54;
    localparam int ENTRY_W = 56;
    localparam int SUM_W = 60;
    localparam int WIN_W = 7;
    localparam int MFI_W = 23;
    localparam logic [WIN_W-1:0] WIN_RESET = 7'd14;
    localparam logic [MFI_W-1:0] MFI_HALF = 23'd3276800;
    localparam logic [MFI_W-1:0] MFI_FULL = 23'd6553600;
    localparam int MARK_UP_BIT = 54;
    localparam int MARK_DN_BIT = 55;
    localparam logic [1:0] ADDR_WINDOW = 2'd0;
endpackage
`default_nettype wire

>>> sv/mfi_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module mfi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> sv/money_flow_index_core.sv
// Money flow index core: top level with control, sums and the ratio divider.
// Depends on mfi_pkg and mfi_ram.
// Each item is one bar: high, low and close prices in ticks plus volume.
// The price sum times volume is the bar's money flow, marked up, down or flat
// against the previous bar; flows are kept in a ring RAM of MAX_WINDOW entries
// and running positive and negative sums cover the last window_length bars.
// The result is 100*pos/(pos+neg) in units of 1/65536 percent, truncated, or
// 50 percent while warming (fewer than window_length+1 bars in the series) or
// when both sums are zero. Items are handled one at a time. An item that needs
// a ratio passes through acceptance, ring read, flow multiply, removal and
// addition, then the divider (a setup step and 23 one-bit restoring steps),
// then the output register load. A warming item, or one with both sums zero,
// skips the divider's restoring steps. The divider's 23 quotient steps are the
// longest part of an item's work. A finished result sits in the output
// register while the next item is accepted and worked; if that register
// still holds an untaken result when the next one is done, the core waits
// and the input stays stalled. The ring needs no clearing pass: an entry's
// contents are used only after this series has written it. window_length is
// written over the APB port, which ignores paddr on writes, and reads back
// at address 0; 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
`default_nettype none
module money_flow_index_core import mfi_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [1:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic                i_first_of_series,
    input  wire logic [PRICE_W-1:0]  i_high_price,
    input  wire logic [PRICE_W-1:0]  i_low_price,
    input  wire logic [PRICE_W-1:0]  i_close_price,
    input  wire logic [VOL_W-1:0]    i_volume,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [MFI_W-1:0]    o_mfi_value,
    output logic                     o_warming
);
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WW = $clog2(MAX_WINDOW + 2);

    typedef enum logic [2:0] {
        S_IDLE, S_FETCH, S_MUL, S_REMOVE, S_ADD, S_SETUP, S_DIV, S_DONE
    } t_state;

    t_state r_state;
    logic [WIN_W-1:0]   r_win;
    logic [PSUM_W-1:0]  r_s, r_prev;
    logic [VOL_W-1:0]   r_vol;
    logic               r_have_prev;
    logic [WW-1:0]      r_bars;
    logic [PW-1:0]      r_ptr;
    logic [SUM_W-1:0]   r_pos, r_neg;
    logic [FLOW_W-1:0]  r_flow;
    logic               r_up, r_dn;
    logic [ENTRY_W-1:0] r_old;
    logic               r_remove, r_warm;
    logic [SUM_W:0]     r_den;
    logic [SUM_W+1:0]   r_rem;
    logic [MFI_W-1:0]   r_low, r_q;
    logic [4:0]         r_cnt;
    logic [MFI_W-1:0]   r_out_val;
    logic               r_out_warm, r_out_valid;

    // Effective window, clamped into 1..MAX_WINDOW.
    logic [8:0]    win9, weff9;
    logic [WW-1:0] w, w1;
    always_comb begin
        win9 = {2'b00, r_win};
        if (win9 == 9'd0) begin
            weff9 = 9'd1;
        end else if (win9 > 9'(MAX_WINDOW)) begin
            weff9 = 9'(MAX_WINDOW);
        end else begin
            weff9 = win9;
        end
        w  = WW'(weff9);
        w1 = w + WW'(1);
    end

    // Slot written window bars ago, modulo MAX_WINDOW.
    logic [9:0]    p10;
    logic [PW-1:0] old_slot;
    always_comb begin
        p10 = 10'(r_ptr);
        if (p10 >= 10'(w)) begin
            old_slot = PW'(p10 - 10'(w));
        end else begin
            old_slot = PW'(p10 + 10'(MAX_WINDOW) - 10'(w));
        end
    end

    logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
    logic               ram_we, ram_re;
    assign ram_re    = (r_state == S_FETCH);
    assign ram_we    = (r_state == S_ADD);
    assign ram_wdata = {r_dn, r_up, r_flow};

    mfi_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_WINDOW), .AW(PW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (old_slot),
        .o_rdata (ram_rdata)
    );

    // Saturating removal and addition on the running sums.
    logic [SUM_W-1:0] old_flow, rm_a, rm_res, add_a, add_res;
    logic [SUM_W:0]   add_sum;
    assign old_flow = SUM_W'(r_old[FLOW_W-1:0]);
    assign rm_a     = r_old[MARK_UP_BIT] ? r_pos : r_neg;
    assign rm_res   = (rm_a > old_flow) ? rm_a - old_flow : '0;
    assign add_a    = r_up ? r_pos : r_neg;
    assign add_sum  = {1'b0, add_a} + (SUM_W+1)'(r_flow);
    assign add_res  = add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0];

    // Dividend pos*6553600 = (pos*100) << 16, built from shifts.
    logic [66:0] pos100;
    assign pos100 = ({7'd0, r_pos} << 6) + ({7'd0, r_pos} << 5) + ({7'd0, r_pos} << 2);

    logic [SUM_W+1:0] trial;
    assign trial = {r_rem[SUM_W:0], r_low[MFI_W-1]};

    logic [PSUM_W-1:0] s_in;
    assign s_in = PSUM_W'(i_high_price) + PSUM_W'(i_low_price) + PSUM_W'(i_close_price);

    logic accept, out_free;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_win       <= WIN_RESET;
            r_have_prev <= 1'b0;
            r_bars      <= '0;
            r_ptr       <= '0;
            r_pos       <= '0;
            r_neg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                r_win <= pwdata[WIN_W-1:0];
            end
            // In S_DONE the load below decides the output valid flag.
            if (r_out_valid && !i_out_stall && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_s   <= s_in;
                        r_vol <= i_volume;
                        if (i_first_of_series) begin
                            r_have_prev <= 1'b0;
                            r_bars      <= '0;
                            r_ptr       <= '0;
                            r_pos       <= '0;
                            r_neg       <= '0;
                        end
                        r_state <= S_FETCH;
                    end
                end
                S_FETCH: begin
                    if (r_bars > w1) begin
                        r_bars <= w1;
                    end
                    r_remove <= (r_bars >= w1);
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_flow  <= FLOW_W'(r_s) * FLOW_W'(r_vol);
                    r_up    <= r_have_prev && (r_s > r_prev);
                    r_dn    <= r_have_prev && (r_s < r_prev);
                    r_old   <= ram_rdata;
                    r_state <= S_REMOVE;
                end
                S_REMOVE: begin
                    if (r_remove && r_old[MARK_UP_BIT]) begin
                        r_pos <= rm_res;
                    end else if (r_remove && r_old[MARK_DN_BIT]) begin
                        r_neg <= rm_res;
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (r_up) begin
                        r_pos <= add_res;
                    end else if (r_dn) begin
                        r_neg <= add_res;
                    end
                    r_ptr <= (r_ptr == PW'(MAX_WINDOW - 1)) ? '0 : r_ptr + PW'(1);
                    r_prev      <= r_s;
                    r_have_prev <= 1'b1;
                    if (r_bars < w1) begin
                        r_bars <= r_bars + WW'(1);
                    end
                    r_warm  <= (r_bars + WW'(1)) < w1;
                    r_state <= S_SETUP;
                end
                S_SETUP: begin
                    r_den <= {1'b0, r_pos} + {1'b0, r_neg};
                    r_rem <= {2'b00, pos100[66:7]};
                    r_low <= {pos100[6:0], 16'd0};
                    r_cnt <= 5'(MFI_W - 1);
                    if (r_warm || (r_pos == '0 && r_neg == '0)) begin
                        r_q     <= MFI_HALF;
                        r_state <= S_DONE;
                    end else begin
                        r_q     <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (trial >= {1'b0, r_den}) begin
                        r_rem <= trial - {1'b0, r_den};
                        r_q   <= {r_q[MFI_W-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_q   <= {r_q[MFI_W-2:0], 1'b0};
                    end
                    r_low <= {r_low[MFI_W-2:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_val   <= r_q;
                        r_out_warm  <= r_warm;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_mfi_value = r_out_val;
    assign o_warming   = r_out_warm;
    assign pready      = 1'b1;
    assign prdata      = (paddr == ADDR_WINDOW) ? {{(32-WIN_W){1'b0}}, r_win} : '0;

    // A warming result always carries the neutral value.
    a_warm_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_warming |-> o_mfi_value == MFI_HALF)
        else $error("warming result is not 50 percent");

    // The index never exceeds 100 percent.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_mfi_value <= MFI_FULL)
        else $error("index above 100 percent");

    // The bar count never passes its saturation point after clamping.
    a_bars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REMOVE |-> r_bars <= w1)
        else $error("bar count beyond window plus one");

    // A result is loaded only into a free output register.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && r_out_valid && i_out_stall |=> r_state == S_DONE)
        else $error("result loaded over a waiting result");
endmodule
`default_nettype wire
